>>> hdl/command_frame_checker_and_acker_core_assert.svh
// Assertion macros used by the checker file cfca_check.sv.
`ifndef COMMAND_FRAME_CHECKER_AND_ACKER_CORE_ASSERT_SVH
`define COMMAND_FRAME_CHECKER_AND_ACKER_CORE_ASSERT_SVH

// Checked on every edge once reset is released.
`define CFCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CFCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cfca_pkg.sv
// Shared constants and types for the command frame checker.
`default_nettype none
package cfca_pkg;

    localparam int COEF_COUNT_DEF = 9;

    localparam logic [7:0] HDR0        = 8'hAA;
    localparam logic [7:0] HDR1        = 8'hAF;
    localparam logic [7:0] CMD_PREAD   = 8'h02;
    localparam logic [7:0] B4_PREAD    = 8'h01;
    localparam logic [7:0] CMD_ACK_LO  = 8'h10;
    localparam logic [7:0] CMD_COEF    = 8'h12;
    localparam logic [7:0] CMD_ACK_HI  = 8'h15;
    localparam logic [7:0] ACK_ID      = 8'hEF;
    localparam logic [7:0] ACK_LEN     = 8'h02;
    // sum of the four fixed leading bytes of an ack frame
    localparam logic [7:0] ACK_PRE_SUM = 8'(HDR0 + HDR0 + ACK_ID + ACK_LEN);

    localparam logic [4:0] PAYLOAD_BASE = 5'd4;
    localparam logic [4:0] INDEX_SAT    = 5'd22;
    localparam int         ACK_BYTES    = 7;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_PREAD = 2'd1;
    localparam logic [1:0] KIND_COEF  = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_PREAD = 2'd1;
    localparam logic [1:0] MODE_COEF  = 2'd2;
    localparam logic [1:0] MODE_ACK   = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] chk;
        logic       bank;
    } t_burst;

endpackage
`default_nettype wire

>>> hdl/cfca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 18,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hdl/cfca_parse.sv
// Frame parser: running sum, header capture, payload writes and frame verdict.
`default_nettype none
module cfca_parse #(
    parameter int COEF_COUNT = cfca_pkg::COEF_COUNT_DEF,
    localparam int DEPTH = 2 * COEF_COUNT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_frame_end,
    input  wire logic             i_busy,
    output logic                  o_we_hi,
    output logic                  o_we_lo,
    output logic      [AW-1:0]    o_waddr,
    output logic      [DEPTH-1:0] o_vld_hi,
    output logic      [DEPTH-1:0] o_vld_lo,
    output logic                  o_start,
    output cfca_pkg::t_burst      o_info
);

    logic [7:0]       r_sum, n_sum;
    logic [4:0]       r_idx, n_idx;
    logic [7:0]       r_h0, n_h0;
    logic [7:0]       r_h1, n_h1;
    logic [7:0]       r_cmd, n_cmd;
    logic             r_b4, n_b4;
    logic             r_bank, n_bank;
    logic [DEPTH-1:0] r_vhi, n_vhi;
    logic [DEPTH-1:0] r_vlo, n_vlo;
    logic             r_start, n_start;
    cfca_pkg::t_burst r_info, n_info;

    logic       accept;
    logic [4:0] off;
    logic [3:0] word;
    logic       in_pay;
    logic       wr;
    logic       frame_ok;
    logic [1:0] mode;

    assign o_stall = i_frame_end && i_busy;
    assign accept  = i_valid && !o_stall;

    assign off    = r_idx - cfca_pkg::PAYLOAD_BASE;
    assign word   = off[4:1];
    assign in_pay = (r_idx >= cfca_pkg::PAYLOAD_BASE) && (r_idx < cfca_pkg::INDEX_SAT)
                    && (word < 4'(COEF_COUNT));
    assign wr      = accept && !i_frame_end && in_pay;
    assign o_we_hi = wr && !off[0];
    assign o_we_lo = wr && off[0];
    assign o_waddr = r_bank ? AW'(word) + AW'(COEF_COUNT) : AW'(word);

    assign frame_ok = (i_rx_byte == r_sum) && (r_h0 == cfca_pkg::HDR0)
                      && (r_h1 == cfca_pkg::HDR1);

    always_comb begin
        priority if (r_cmd == cfca_pkg::CMD_PREAD) begin
            mode = r_b4 ? cfca_pkg::MODE_PREAD : cfca_pkg::MODE_NONE;
        end else if (r_cmd == cfca_pkg::CMD_COEF) begin
            mode = cfca_pkg::MODE_COEF;
        end else if (r_cmd >= cfca_pkg::CMD_ACK_LO && r_cmd <= cfca_pkg::CMD_ACK_HI) begin
            mode = cfca_pkg::MODE_ACK;
        end else begin
            mode = cfca_pkg::MODE_NONE;
        end
    end

    always_comb begin
        n_sum   = r_sum;
        n_idx   = r_idx;
        n_h0    = r_h0;
        n_h1    = r_h1;
        n_cmd   = r_cmd;
        n_b4    = r_b4;
        n_bank  = r_bank;
        n_vhi   = r_vhi;
        n_vlo   = r_vlo;
        n_start = 1'b0;
        n_info  = r_info;
        if (accept && i_frame_end) begin
            n_start     = frame_ok && (mode != cfca_pkg::MODE_NONE);
            n_info.mode = mode;
            n_info.cmd  = r_cmd;
            n_info.sum  = r_sum;
            n_info.chk  = cfca_pkg::ACK_PRE_SUM + r_cmd + r_sum;
            n_info.bank = r_bank;
            n_sum  = '0;
            n_idx  = '0;
            n_h0   = '0;
            n_h1   = '0;
            n_cmd  = '0;
            n_b4   = 1'b0;
            n_bank = !r_bank;
            // next frame fills the other bank; it starts out empty
            for (int a = 0; a < DEPTH; a++) begin
                if ((a >= COEF_COUNT) != r_bank) begin
                    n_vhi[a] = 1'b0;
                    n_vlo[a] = 1'b0;
                end
            end
        end else if (accept) begin
            n_sum = r_sum + i_rx_byte;
            if (r_idx < cfca_pkg::INDEX_SAT) begin
                n_idx = r_idx + 5'd1;
            end
            if (r_idx == 5'd0) begin
                n_h0 = i_rx_byte;
            end
            if (r_idx == 5'd1) begin
                n_h1 = i_rx_byte;
            end
            if (r_idx == 5'd2) begin
                n_cmd = i_rx_byte;
            end
            if (r_idx == cfca_pkg::PAYLOAD_BASE) begin
                n_b4 = (i_rx_byte == cfca_pkg::B4_PREAD);
            end
            if (o_we_hi) begin
                n_vhi[o_waddr] = 1'b1;
            end
            if (o_we_lo) begin
                n_vlo[o_waddr] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_idx   <= '0;
            r_h0    <= '0;
            r_h1    <= '0;
            r_cmd   <= '0;
            r_b4    <= 1'b0;
            r_bank  <= 1'b0;
            r_vhi   <= '0;
            r_vlo   <= '0;
            r_start <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            r_h0    <= n_h0;
            r_h1    <= n_h1;
            r_cmd   <= n_cmd;
            r_b4    <= n_b4;
            r_bank  <= n_bank;
            r_vhi   <= n_vhi;
            r_vlo   <= n_vlo;
            r_start <= n_start;
        end
        r_info <= n_info;
    end

    assign o_vld_hi = r_vhi;
    assign o_vld_lo = r_vlo;
    assign o_start  = r_start;
    assign o_info   = r_info;

endmodule
`default_nettype wire

>>> hdl/cfca_burst.sv
// Result burst generator: steps through a frame's results, reads coefficients, output register.
`default_nettype none
module cfca_burst #(
    parameter int COEF_COUNT = cfca_pkg::COEF_COUNT_DEF,
    localparam int DEPTH = 2 * COEF_COUNT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire cfca_pkg::t_burst    i_info,
    output logic                     o_busy,
    output logic       [AW-1:0]      o_raddr,
    input  wire logic  [7:0]         i_rd_hi,
    input  wire logic  [7:0]         i_rd_lo,
    input  wire logic  [DEPTH-1:0]   i_vld_hi,
    input  wire logic  [DEPTH-1:0]   i_vld_lo,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic       [1:0]         o_kind,
    output logic       [7:0]         o_tx_byte,
    output logic       [3:0]         o_coef_index,
    output logic signed [15:0]       o_coef_value,
    output logic                     o_burst_last
);

    cfca_pkg::t_burst r_info;
    logic             r_run;
    logic [4:0]       r_cnt;
    logic [4:0]       r_last_step;
    logic             r_s1_valid;
    logic [4:0]       r_s1_step;
    logic             r_s1_last;
    logic [AW-1:0]    r_s1_addr;

    logic              r_o_valid;
    logic [1:0]        r_o_kind;
    logic [7:0]        r_o_tx;
    logic [3:0]        r_o_idx;
    logic [15:0]       r_o_val;
    logic              r_o_last;

    logic        s1_move;
    logic        issue;
    logic [AW-1:0] cnt_addr;
    logic        s1_coef;
    logic [4:0]  ack_k;
    logic [1:0]  s1_kind;
    logic [7:0]  s1_tx;
    logic [3:0]  s1_idx;
    logic [15:0] s1_val;

    assign s1_move = r_s1_valid && (!r_o_valid || !i_stall);
    assign issue   = r_run && (!r_s1_valid || s1_move);
    assign o_busy  = i_start || r_run || r_s1_valid;

    always_comb begin
        cnt_addr = '0;
        if (r_info.mode == cfca_pkg::MODE_COEF && r_cnt < 5'(COEF_COUNT)) begin
            cnt_addr = r_info.bank ? AW'(r_cnt) + AW'(COEF_COUNT) : AW'(r_cnt);
        end
    end

    // hold the read address while stage 1 waits so the RAM output stays put
    assign o_raddr = issue ? cnt_addr : r_s1_addr;

    assign s1_coef = (r_info.mode == cfca_pkg::MODE_COEF) && (r_s1_step < 5'(COEF_COUNT));
    assign ack_k   = (r_info.mode == cfca_pkg::MODE_COEF) ? r_s1_step - 5'(COEF_COUNT)
                                                           : r_s1_step;

    always_comb begin
        s1_kind = cfca_pkg::KIND_ACK;
        s1_tx   = '0;
        s1_idx  = '0;
        s1_val  = '0;
        priority if (r_info.mode == cfca_pkg::MODE_PREAD) begin
            s1_kind = cfca_pkg::KIND_PREAD;
        end else if (s1_coef) begin
            s1_kind = cfca_pkg::KIND_COEF;
            s1_idx  = r_s1_step[3:0];
            s1_val  = {i_vld_hi[r_s1_addr] ? i_rd_hi : 8'h00,
                       i_vld_lo[r_s1_addr] ? i_rd_lo : 8'h00};
        end else begin
            unique case (ack_k[2:0])
                3'd0:    s1_tx = cfca_pkg::HDR0;
                3'd1:    s1_tx = cfca_pkg::HDR0;
                3'd2:    s1_tx = cfca_pkg::ACK_ID;
                3'd3:    s1_tx = cfca_pkg::ACK_LEN;
                3'd4:    s1_tx = r_info.cmd;
                3'd5:    s1_tx = r_info.sum;
                default: s1_tx = r_info.chk;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_start) begin
                r_run <= 1'b1;
            end else if (issue && r_cnt == r_last_step) begin
                r_run <= 1'b0;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        if (i_start) begin
            r_info <= i_info;
            r_cnt  <= '0;
            priority if (i_info.mode == cfca_pkg::MODE_PREAD) begin
                r_last_step <= '0;
            end else if (i_info.mode == cfca_pkg::MODE_COEF) begin
                r_last_step <= 5'(COEF_COUNT + cfca_pkg::ACK_BYTES - 1);
            end else begin
                r_last_step <= 5'(cfca_pkg::ACK_BYTES - 1);
            end
        end else if (issue) begin
            r_cnt <= r_cnt + 5'd1;
        end
        if (issue) begin
            r_s1_step <= r_cnt;
            r_s1_last <= (r_cnt == r_last_step);
            r_s1_addr <= cnt_addr;
        end
        if (s1_move) begin
            r_o_kind <= s1_kind;
            r_o_tx   <= s1_tx;
            r_o_idx  <= s1_idx;
            r_o_val  <= s1_val;
            r_o_last <= r_s1_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_o_kind;
    assign o_tx_byte    = r_o_tx;
    assign o_coef_index = r_o_idx;
    assign o_coef_value = signed'(r_o_val);
    assign o_burst_last = r_o_last;

endmodule
`default_nettype wire

>>> hdl/command_frame_checker_and_acker_core.sv
// Command frame checker and acknowledger core: top level.
// Takes one received byte per cycle. A frame's final byte is held off (o_in_stall)
// while the result burst of the previous frame is still being generated; every
// other byte is taken at once. A frame that passes its checks yields 1 result
// (parameter-read request), 7 results (ack frame) or COEF_COUNT+7 results
// (coefficients, then ack), one per cycle while i_out_stall is low; the first
// comes out through the verdict, burst run, RAM read and output registers.
// Payload words sit in two 2*COEF_COUNT x 8 RAMs (high and low byte) split into
// two banks that alternate per frame, so the next frame fills one bank while the
// burst reads the other. Per-entry valid bits make bytes never received read as
// zero; no clearing pass is needed after reset.
`default_nettype none
module command_frame_checker_and_acker_core #(
    parameter int COEF_COUNT = cfca_pkg::COEF_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic       [1:0]        o_kind,
    output logic       [7:0]        o_tx_byte,
    output logic       [3:0]        o_coef_index,
    output logic signed [15:0]      o_coef_value,
    output logic                    o_burst_last
);

    localparam int DEPTH = 2 * COEF_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic             busy;
    logic             we_hi;
    logic             we_lo;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [7:0]       rd_hi;
    logic [7:0]       rd_lo;
    logic [DEPTH-1:0] vld_hi;
    logic [DEPTH-1:0] vld_lo;
    logic             start;
    cfca_pkg::t_burst info;

    cfca_parse #(.COEF_COUNT(COEF_COUNT)) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .i_busy      (busy),
        .o_we_hi     (we_hi),
        .o_we_lo     (we_lo),
        .o_waddr     (waddr),
        .o_vld_hi    (vld_hi),
        .o_vld_lo    (vld_lo),
        .o_start     (start),
        .o_info      (info)
    );

    cfca_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (we_hi),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rd_hi)
    );

    cfca_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (we_lo),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rd_lo)
    );

    cfca_burst #(.COEF_COUNT(COEF_COUNT)) u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_info       (info),
        .o_busy       (busy),
        .o_raddr      (raddr),
        .i_rd_hi      (rd_hi),
        .i_rd_lo      (rd_lo),
        .i_vld_hi     (vld_hi),
        .i_vld_lo     (vld_lo),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_coef_index (o_coef_index),
        .o_coef_value (o_coef_value),
        .o_burst_last (o_burst_last)
    );

endmodule
`default_nettype wire

>>> hdl/cfca_check.sv
// Port-level checker for the command frame checker core, with its bind.
`default_nettype none
`include "command_frame_checker_and_acker_core_assert.svh"
module cfca_check #(
    parameter int COEF_COUNT = cfca_pkg::COEF_COUNT_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_rx_byte,
    input wire logic        i_frame_end,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_tx_byte,
    input wire logic [3:0]  o_coef_index,
    input wire logic [15:0] o_coef_value,
    input wire logic        o_burst_last
);

    // a held result keeps its payload
    `CFCA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_byte) && $stable(o_coef_value) && $stable(o_burst_last), "stalled result changed")

    // only a frame's final byte is ever held off
    `CFCA_ASSERT_ALWAYS(a_stall_end, i_clk, o_in_stall |-> i_frame_end, "stall on a non-final byte")

    `CFCA_ASSERT(a_kind_fields, i_clk, i_rst_n, o_out_valid && o_kind != cfca_pkg::KIND_ACK |-> o_tx_byte == 8'h00 && o_kind != 2'd3, "bad fields for request kind")

    `CFCA_ASSERT(a_coef_idx, i_clk, i_rst_n, o_out_valid && o_kind == cfca_pkg::KIND_COEF |-> o_coef_index < 4'(COEF_COUNT), "coefficient index out of range")

endmodule

bind command_frame_checker_and_acker_core cfca_check #(.COEF_COUNT(COEF_COUNT)) u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_rx_byte    (i_rx_byte),
    .i_frame_end  (i_frame_end),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kind       (o_kind),
    .o_tx_byte    (o_tx_byte),
    .o_coef_index (o_coef_index),
    .o_coef_value (o_coef_value),
    .o_burst_last (o_burst_last)
);
`default_nettype wire
